// ===== rtl/yenc_pd_pkg.sv =====
package yenc_pd_pkg;

   // operation codes of the request channel
   localparam logic [3:0] OP_BYTE        = 4'd0;
   localparam logic [3:0] OP_LINE_END    = 4'd1;
   localparam logic [3:0] OP_FIRST_BEGIN = 4'd2;
   localparam logic [3:0] OP_NEXT_BEGIN  = 4'd3;
   localparam logic [3:0] OP_PART_LINE   = 4'd4;
   localparam logic [3:0] OP_END_LINE    = 4'd5;
   localparam logic [3:0] OP_HEADER_END  = 4'd6;
   localparam logic [3:0] OP_ARTICLE_END = 4'd7;
   localparam logic [3:0] OP_STREAM_END  = 4'd8;

   // result kinds
   localparam logic [1:0] KIND_BYTE     = 2'd0;
   localparam logic [1:0] KIND_ERROR    = 2'd1;
   localparam logic [1:0] KIND_COMPLETE = 2'd2;

   // error codes, also bit positions in the error mask
   localparam int ERR_BAD_BEGIN   = 0;
   localparam int ERR_BAD_PART    = 1;
   localparam int ERR_BAD_END     = 2;
   localparam int ERR_ESCAPE_EOL  = 3;
   localparam int ERR_MISSING_END = 4;
   localparam int ERR_PART_NUMBER = 5;
   localparam int ERR_SIZE        = 6;
   localparam int ERR_PART_BEGIN  = 7;
   localparam int ERR_PART_SIZE   = 8;
   localparam int ERR_PART_CRC    = 9;
   localparam int ERR_FILE_CRC    = 10;
   localparam int ERR_PART_END    = 11;
   localparam int NUM_ERRORS      = 12;

   localparam logic [7:0]  BYTE_OFFSET = 8'd42;
   localparam logic [7:0]  ESC_OFFSET  = 8'd64;
   localparam logic [7:0]  ESC_CHAR    = 8'h3D;     // '='
   localparam logic [32:0] UNSET33     = '1;
   localparam logic [31:0] CRC_POLY    = 32'hEDB88320;

   typedef struct packed {
      logic [3:0]  operation;
      logic [7:0]  data_byte;
      logic [15:0] part_number;
      logic        has_part_number;
      logic [31:0] length_value;
      logic        has_length;
      logic [31:0] offset_value;
      logic        has_offset;
      logic [31:0] part_crc_given;
      logic        has_part_crc;
      logic [31:0] file_crc_given;
      logic        has_file_crc;
   } req_type;

   // all results caused by one request; emitted byte, errors low to high, complete
   typedef struct packed {
      logic                  complete;
      logic [NUM_ERRORS-1:0] err_mask;
      logic [7:0]            byte_val;
      logic                  byte_valid;
   } rec_type;

   function automatic logic [31:0] crc_add(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = ~crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return ~c;
   endfunction

endpackage

// ===== rtl/yenc_pd_core.sv =====
module yenc_pd_core #(
   parameter int PositionBits = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  yenc_pd_pkg::req_type req_data,
   input  logic                 queue_full,
   output logic                 push_valid,
   output yenc_pd_pkg::rec_type push_rec
);

   localparam int CmpW = (PositionBits > 33) ? PositionBits : 33;
   localparam int SumW = (PositionBits >= 64) ? 64 :
                         ((PositionBits > 32) ? PositionBits : 32) + 1;

   localparam logic [2:0] MODE_HEADER = 3'd0;
   localparam logic [2:0] MODE_PRE    = 3'd1;
   localparam logic [2:0] MODE_BEGIN  = 3'd2;
   localparam logic [2:0] MODE_DATA   = 3'd3;
   localparam logic [2:0] MODE_POST   = 3'd4;

   logic                    in_valid_ff, in_valid_in;
   yenc_pd_pkg::req_type    in_ff;
   logic [2:0]              mode_ff, mode_in;
   logic                    esc_ff, esc_in;
   logic [15:0]             counter_ff, counter_in;
   logic [32:0]             file_size_ff, file_size_in;
   logic [PositionBits-1:0] position_ff, position_in;
   logic [PositionBits-1:0] part_begin_ff, part_begin_in;
   logic [32:0]             part_end_ff, part_end_in;
   logic [31:0]             file_crc_ff, file_crc_in;
   logic [31:0]             part_crc_ff, part_crc_in;

   logic                 advance;
   logic                 active;
   logic                 start, first;
   logic [7:0]           dec;
   logic [15:0]          cnt_next;
   logic [32:0]          fsize_base;
   logic [31:0]          off_m1;
   yenc_pd_pkg::rec_type rec;

   assign advance    = in_valid_ff && !queue_full;
   assign req_ready  = !in_valid_ff || advance;
   assign active     = (mode_ff == MODE_BEGIN) || (mode_ff == MODE_DATA);
   assign push_rec   = rec;
   assign push_valid = advance && (rec != '0);

   always_comb begin
      mode_in       = mode_ff;
      esc_in        = esc_ff;
      counter_in    = counter_ff;
      file_size_in  = file_size_ff;
      position_in   = position_ff;
      part_begin_in = part_begin_ff;
      part_end_in   = part_end_ff;
      file_crc_in   = file_crc_ff;
      part_crc_in   = part_crc_ff;
      rec           = '0;
      start         = 1'b0;
      first         = 1'b0;
      dec           = in_ff.data_byte - yenc_pd_pkg::BYTE_OFFSET
                      - (esc_ff ? yenc_pd_pkg::ESC_OFFSET : 8'd0);
      off_m1        = in_ff.offset_value - 32'd1;

      if (in_ff.operation == yenc_pd_pkg::OP_BYTE) begin
         if (active) begin
            mode_in = MODE_DATA;
            if (!esc_ff && in_ff.data_byte == yenc_pd_pkg::ESC_CHAR) begin
               esc_in = 1'b1;
            end else begin
               esc_in         = 1'b0;
               position_in    = position_ff + PositionBits'(1);
               file_crc_in    = yenc_pd_pkg::crc_add(file_crc_ff, dec);
               part_crc_in    = yenc_pd_pkg::crc_add(part_crc_ff, dec);
               rec.byte_valid = 1'b1;
               rec.byte_val   = dec;
            end
         end
      end else begin
         esc_in = 1'b0;
         case (in_ff.operation)
            yenc_pd_pkg::OP_LINE_END: begin
               if (active) begin
                  rec.err_mask[yenc_pd_pkg::ERR_ESCAPE_EOL] = esc_ff;
                  mode_in = MODE_DATA;
               end
            end
            yenc_pd_pkg::OP_FIRST_BEGIN: begin
               start = 1'b1;
               first = 1'b1;
            end
            yenc_pd_pkg::OP_NEXT_BEGIN: begin
               if (mode_ff == MODE_PRE) begin
                  start = 1'b1;
               end else if (mode_ff != MODE_HEADER) begin
                  rec.err_mask[yenc_pd_pkg::ERR_BAD_BEGIN] = 1'b1;
               end
            end
            yenc_pd_pkg::OP_PART_LINE: begin
               if (mode_ff == MODE_BEGIN) begin
                  if (in_ff.has_offset && (in_ff.offset_value == 32'd0 ||
                      CmpW'(off_m1) != CmpW'(part_begin_ff))) begin
                     rec.err_mask[yenc_pd_pkg::ERR_PART_BEGIN] = 1'b1;
                  end
                  if (in_ff.has_length) begin
                     part_end_in = {1'b0, in_ff.length_value};
                  end
                  mode_in = MODE_DATA;
               end else if (mode_ff != MODE_HEADER) begin
                  rec.err_mask[yenc_pd_pkg::ERR_BAD_PART] = 1'b1;
               end
            end
            yenc_pd_pkg::OP_END_LINE: begin
               if (active) begin
                  rec.err_mask[yenc_pd_pkg::ERR_PART_NUMBER] = in_ff.has_part_number &&
                     (in_ff.part_number != counter_ff);
                  rec.err_mask[yenc_pd_pkg::ERR_PART_SIZE] = in_ff.has_length &&
                     (SumW'(part_begin_ff) + SumW'(in_ff.length_value) != SumW'(position_ff));
                  rec.err_mask[yenc_pd_pkg::ERR_PART_CRC] = in_ff.has_part_crc &&
                     (in_ff.part_crc_given != part_crc_ff);
                  rec.err_mask[yenc_pd_pkg::ERR_FILE_CRC] = in_ff.has_file_crc &&
                     (in_ff.file_crc_given != file_crc_ff);
                  rec.err_mask[yenc_pd_pkg::ERR_PART_END] =
                     (part_end_ff != yenc_pd_pkg::UNSET33) &&
                     (CmpW'(position_ff) != CmpW'(part_end_ff));
                  rec.complete = (file_size_ff != yenc_pd_pkg::UNSET33) &&
                     (CmpW'(position_ff) == CmpW'(file_size_ff));
                  mode_in = MODE_POST;
               end else if (mode_ff != MODE_HEADER) begin
                  rec.err_mask[yenc_pd_pkg::ERR_BAD_END] = 1'b1;
               end
            end
            yenc_pd_pkg::OP_HEADER_END: begin
               mode_in = MODE_PRE;
            end
            yenc_pd_pkg::OP_ARTICLE_END: begin
               rec.err_mask[yenc_pd_pkg::ERR_MISSING_END] = (mode_ff != MODE_POST);
               mode_in = MODE_HEADER;
            end
            yenc_pd_pkg::OP_STREAM_END: begin
               rec.err_mask[yenc_pd_pkg::ERR_MISSING_END] = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // first begin restarts the file before opening the part
      cnt_next   = (first ? 16'd0 : counter_ff) + 16'd1;
      fsize_base = first ? yenc_pd_pkg::UNSET33 : file_size_ff;
      if (start) begin
         counter_in    = cnt_next;
         part_begin_in = first ? '0 : position_ff;
         part_end_in   = yenc_pd_pkg::UNSET33;
         part_crc_in   = '0;
         if (first) begin
            file_crc_in  = '0;
            position_in  = '0;
            file_size_in = in_ff.has_length ? {1'b0, in_ff.length_value}
                                            : yenc_pd_pkg::UNSET33;
         end
         rec.err_mask[yenc_pd_pkg::ERR_PART_NUMBER] = in_ff.has_part_number &&
            (in_ff.part_number != cnt_next);
         rec.err_mask[yenc_pd_pkg::ERR_SIZE] = !first && in_ff.has_length &&
            (fsize_base != {1'b0, in_ff.length_value});
         mode_in = MODE_BEGIN;
      end
   end

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         mode_ff       <= MODE_HEADER;
         esc_ff        <= 1'b0;
         counter_ff    <= '0;
         file_size_ff  <= yenc_pd_pkg::UNSET33;
         position_ff   <= '0;
         part_begin_ff <= '0;
         part_end_ff   <= yenc_pd_pkg::UNSET33;
         file_crc_ff   <= '0;
         part_crc_ff   <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            mode_ff       <= mode_in;
            esc_ff        <= esc_in;
            counter_ff    <= counter_in;
            file_size_ff  <= file_size_in;
            position_ff   <= position_in;
            part_begin_ff <= part_begin_in;
            part_end_ff   <= part_end_in;
            file_crc_ff   <= file_crc_in;
            part_crc_ff   <= part_crc_in;
         end
      end
   end

endmodule

// ===== rtl/yenc_pd_queue.sv =====
module yenc_pd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  yenc_pd_pkg::rec_type push_rec,
   output logic                 queue_full,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [7:0]           rsp_decoded_byte,
   output logic [3:0]           rsp_error_code,
   output logic                 rsp_last
);

   localparam int FlagW = yenc_pd_pkg::NUM_ERRORS + 2;

   yenc_pd_pkg::rec_type rec_ff [2];
   logic                 wr_ff, wr_in;
   logic                 rd_ff, rd_in;
   logic [1:0]           count_ff, count_in;

   yenc_pd_pkg::rec_type head;
   logic [FlagW-1:0]     flags, sel, remain;
   logic                 pop, beat;

   assign head  = rec_ff[rd_ff];
   // emission order: byte, errors by ascending code, file complete
   assign flags = {head.complete, head.err_mask, head.byte_valid};
   assign sel   = flags & (~flags + FlagW'(1));
   assign remain = flags & ~sel;

   assign queue_full = (count_ff == 2'd2);
   assign rsp_valid  = (count_ff != 2'd0);
   assign beat       = rsp_valid && rsp_ready;
   assign pop        = beat && (remain == '0);
   assign rsp_last   = (remain == '0);

   always_comb begin
      rsp_kind         = yenc_pd_pkg::KIND_ERROR;
      rsp_decoded_byte = 8'd0;
      rsp_error_code   = 4'd0;
      if (sel[0]) begin
         rsp_kind         = yenc_pd_pkg::KIND_BYTE;
         rsp_decoded_byte = head.byte_val;
      end else if (sel[FlagW-1]) begin
         rsp_kind = yenc_pd_pkg::KIND_COMPLETE;
      end
      for (int i = 0; i < yenc_pd_pkg::NUM_ERRORS; i++) begin
         if (sel[i+1]) begin
            rsp_error_code = rsp_error_code | 4'(i);
         end
      end
   end

   always_comb begin
      wr_in    = push_valid ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push_valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         rec_ff[wr_ff] <= push_rec;
      end
      if (beat && !pop) begin
         rec_ff[rd_ff] <= {remain[FlagW-1], remain[FlagW-2:1], head.byte_val, remain[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/yenc_part_decoder_unit.sv =====
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    operation, data_byte, part/length/offset/crc fields
// rsp      out        rsp_valid/rsp_ready    kind, decoded_byte, error_code, last
//
// A request beat is registered, decoded and applied to the state once the queue has room;
// its results (0 to 6) enter a two-entry result queue and leave one beat per cycle while
// rsp_ready is high. With one result or none per request and rsp_ready high, the unit takes
// a request every cycle; a request with more results holds the queue head until all have left.
// Synchronous active-high reset; no clearing pass. req_ready does not depend on
// rsp_ready: stalls on rsp back up only once the queue is full.
module yenc_part_decoder_unit #(
   parameter int PositionBits = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_operation,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_part_number,
   input  logic        req_has_part_number,
   input  logic [31:0] req_length_value,
   input  logic        req_has_length,
   input  logic [31:0] req_offset_value,
   input  logic        req_has_offset,
   input  logic [31:0] req_part_crc_given,
   input  logic        req_has_part_crc,
   input  logic [31:0] req_file_crc_given,
   input  logic        req_has_file_crc,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_decoded_byte,
   output logic [3:0]  rsp_error_code,
   output logic        rsp_last
);

   yenc_pd_pkg::req_type req_data;
   yenc_pd_pkg::rec_type push_rec;
   logic                 push_valid;
   logic                 queue_full;

   assign req_data = '{
      operation:       req_operation,
      data_byte:       req_data_byte,
      part_number:     req_part_number,
      has_part_number: req_has_part_number,
      length_value:    req_length_value,
      has_length:      req_has_length,
      offset_value:    req_offset_value,
      has_offset:      req_has_offset,
      part_crc_given:  req_part_crc_given,
      has_part_crc:    req_has_part_crc,
      file_crc_given:  req_file_crc_given,
      has_file_crc:    req_has_file_crc
   };

   yenc_pd_core #(
      .PositionBits(PositionBits)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_rec   (push_rec)
   );

   yenc_pd_queue u_queue (
      .clock            (clock),
      .reset            (reset),
      .push_valid       (push_valid),
      .push_rec         (push_rec),
      .queue_full       (queue_full),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_decoded_byte (rsp_decoded_byte),
      .rsp_error_code   (rsp_error_code),
      .rsp_last         (rsp_last)
   );

endmodule
